// File: rtl/wsrq_pkg.sv
// shared types, codes and defaults for the work stealing run queues
package wsrq_pkg;

  localparam int MAX_CPUS_DEF    = 8;
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int TASK_BITS_DEF   = 16;
  localparam int NODE_BITS_DEF   = 2;

  // configuration register indexes
  localparam logic [1:0] REG_ACTIVE_CPUS = 2'd0;
  localparam logic [1:0] REG_STEAL_MIN   = 2'd1;
  localparam logic [1:0] REG_STEAL_MAX   = 2'd2;
  localparam logic [1:0] REG_NODE_MAP    = 2'd3;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PEEK    = 2'd2,
    OP_STEAL   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADCPU = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    latch;
    logic    set_status;
    status_t status_code;
    logic    push_tid;
    logic    take_head;
    logic    pop_c;
    logic    rd_vic;
    logic    pop_v;
    logic    scan_init;
    logic    scan_pass;
    logic    scan_step;
    logic    grab;
    logic    move;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic bad;
    logic full;
    logic empty;
    logic pass;
    logic scan_end;
    logic eligible;
    logic last;
  } dp_stat_t;

endpackage

// File: rtl/work_stealing_run_queues_top.sv
// Per-processor FIFO run queues with NUMA-aware work stealing. Every item
// returns one result. Dequeue and peek go through an extra read state
// because of the registered read of the task memory. A steal scans the
// victims, same node first and then the other-node pass, and then uses
// the single memory port for one read then one move step per stolen task.
// A new item is accepted once the previous result has been transferred
// out. No clearing pass is needed after reset.
module work_stealing_run_queues_top import wsrq_pkg::*; #(
  parameter int MAX_CPUS    = MAX_CPUS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TASK_BITS   = TASK_BITS_DEF,
  parameter int NODE_BITS   = NODE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           operation,
  input  logic [2:0]           cpu,
  input  logic [TASK_BITS-1:0] task_id,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [TASK_BITS-1:0] task_out,
  output logic                 task_valid,
  output logic [1:0]           status,
  output logic [6:0]           queue_count,
  output logic [2:0]           victim,
  output logic [5:0]           moved_count
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  wsrq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  wsrq_dpath #(
    .MAX_CPUS    (MAX_CPUS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TASK_BITS   (TASK_BITS),
    .NODE_BITS   (NODE_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .operation   (operation),
    .cpu         (cpu),
    .task_id     (task_id),
    .cmd         (cmd),
    .stat        (stat),
    .task_out    (task_out),
    .task_valid  (task_valid),
    .status      (status),
    .queue_count (queue_count),
    .victim      (victim),
    .moved_count (moved_count)
  );

endmodule

// File: rtl/wsrq_dpath.sv
// datapath: queue pointers, task memory, steal scan and result registers
module wsrq_dpath import wsrq_pkg::*; #(
  parameter int MAX_CPUS    = MAX_CPUS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TASK_BITS   = TASK_BITS_DEF,
  parameter int NODE_BITS   = NODE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic [1:0]           operation,
  input  logic [2:0]           cpu,
  input  logic [TASK_BITS-1:0] task_id,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic [TASK_BITS-1:0] task_out,
  output logic                 task_valid,
  output logic [1:0]           status,
  output logic [6:0]           queue_count,
  output logic [2:0]           victim,
  output logic [5:0]           moved_count
);

  localparam int CB    = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int SW    = (CB + 1 > 5) ? CB + 1 : 5;
  localparam int IW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int TW    = (CW > 7) ? CW : 7;
  localparam int DEPTH = MAX_CPUS * QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [3:0]  cfg_active;
  logic [6:0]  cfg_min;
  logic [6:0]  cfg_max;
  logic [15:0] cfg_map;

  logic [1:0]           op_r;
  logic [SW-1:0]        c_r;
  logic [TASK_BITS-1:0] tid_r;

  logic [IW-1:0] head [MAX_CPUS];
  logic [IW-1:0] tail [MAX_CPUS];
  logic [CW-1:0] cnt  [MAX_CPUS];

  logic [TASK_BITS-1:0] mem [DEPTH];
  logic [TASK_BITS-1:0] rdata;

  logic          pass_r;
  logic [SW-1:0] i_r;
  logic [SW-1:0] v_r;
  logic [TW-1:0] take_r;
  logic [TW-1:0] k_r;

  logic [TASK_BITS-1:0] task_r;
  logic                 valid_r;
  status_t              status_r;
  logic [5:0]           moved_r;

  function automatic logic [NODE_BITS-1:0] node_of(input logic [SW-1:0] x,
                                                   input logic [15:0] map);
    int pos;
    pos = int'(x) * NODE_BITS;
    if (pos >= 16) return '0;
    return NODE_BITS'(map >> pos);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] x,
                                            input logic [IW-1:0] idx);
    return AW'(int'(x) * QUEUE_DEPTH + int'(idx));
  endfunction

  function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] idx);
    return (int'(idx) == QUEUE_DEPTH - 1) ? '0 : IW'(int'(idx) + 1);
  endfunction

  // processors in use and requester checks
  logic [SW-1:0] n_cpus;
  logic [CB-1:0] ci;
  assign n_cpus = (int'(cfg_active) > MAX_CPUS) ? SW'(MAX_CPUS) : SW'(cfg_active);
  assign ci     = c_r[CB-1:0];

  // candidate victim for the current scan step
  logic [SW-1:0]  sum_s;
  logic [SW-1:0]  v_s;
  logic [CW-1:0]  have_s;
  logic [TW-1:0]  half_s;
  logic [TW-1:0]  take_s;
  logic           same_s;
  always_comb begin
    sum_s  = i_r + c_r;
    v_s    = (sum_s >= n_cpus) ? sum_s - n_cpus : sum_s;
    have_s = cnt[v_s[CB-1:0]];
    half_s = TW'(have_s >> 1);
    take_s = (TW'(cfg_max) > half_s) ? half_s : TW'(cfg_max);
    same_s = node_of(v_s, cfg_map) == node_of(c_r, cfg_map);
  end

  always_comb begin
    stat.op       = op_t'(op_r);
    stat.bad      = c_r >= n_cpus;
    stat.full     = cnt[ci] >= CW'(QUEUE_DEPTH);
    stat.empty    = cnt[ci] == '0;
    stat.pass     = pass_r;
    stat.scan_end = i_r >= n_cpus;
    stat.eligible = (same_s == !pass_r) && (TW'(have_s) >= TW'(cfg_min)) && (take_s != '0);
    stat.last     = (k_r + TW'(1)) == take_r;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_active <= 4'd1;
      cfg_min    <= 7'd2;
      cfg_max    <= 7'd4;
      cfg_map    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_CPUS: cfg_active <= cfg_data[3:0];
        REG_STEAL_MIN:   cfg_min    <= cfg_data[6:0];
        REG_STEAL_MAX:   cfg_max    <= cfg_data[6:0];
        REG_NODE_MAP:    cfg_map    <= cfg_data;
        default: ;
      endcase
    end
  end

  // push requests into the requester queue
  logic                 push;
  logic [TASK_BITS-1:0] push_data;
  assign push      = cmd.push_tid || (cmd.move && k_r != '0 && !stat.full);
  assign push_data = cmd.push_tid ? tid_r : rdata;

  // task memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (push) mem[addr_of(c_r, tail[ci])] <= push_data;
    if (cmd.rd_vic) rdata <= mem[addr_of(v_r, head[v_r[CB-1:0]])];
    else            rdata <= mem[addr_of(c_r, head[ci])];
  end

  // queue pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < MAX_CPUS; q++) begin
        head[q] <= '0;
        tail[q] <= '0;
        cnt[q]  <= '0;
      end
    end else begin
      if (cmd.pop_c) begin
        head[ci] <= inc_idx(head[ci]);
        cnt[ci]  <= cnt[ci] - CW'(1);
      end
      if (cmd.pop_v) begin
        head[v_r[CB-1:0]] <= inc_idx(head[v_r[CB-1:0]]);
        cnt[v_r[CB-1:0]]  <= cnt[v_r[CB-1:0]] - CW'(1);
      end
      if (push) begin
        tail[ci] <= inc_idx(tail[ci]);
        cnt[ci]  <= cnt[ci] + CW'(1);
      end
    end
  end

  // input capture, scan state and result registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r     <= operation;
      c_r      <= SW'(cpu);
      tid_r    <= task_id;
      task_r   <= '0;
      valid_r  <= 1'b0;
      status_r <= ST_OK;
      v_r      <= '0;
      moved_r  <= '0;
    end
    if (cmd.set_status) status_r <= cmd.status_code;
    if (cmd.take_head) begin
      task_r  <= rdata;
      valid_r <= 1'b1;
    end
    if (cmd.scan_init || cmd.scan_pass) begin
      pass_r <= cmd.scan_pass;
      i_r    <= SW'(1);
    end
    if (cmd.scan_step) i_r <= i_r + SW'(1);
    if (cmd.grab) begin
      v_r    <= v_s;
      take_r <= take_s;
      k_r    <= '0;
    end
    if (cmd.move) begin
      k_r <= k_r + TW'(1);
      if (k_r == '0) begin
        task_r   <= rdata;
        valid_r  <= 1'b1;
        status_r <= ST_OK;
      end else if (!stat.full) begin
        moved_r <= moved_r + 6'd1;
      end
    end
  end

  assign task_out    = task_r;
  assign task_valid  = valid_r;
  assign status      = status_r;
  assign queue_count = stat.bad ? 7'd0 : 7'(cnt[ci]);
  assign victim      = 3'(v_r);
  assign moved_count = moved_r;

endmodule

// File: rtl/wsrq_ctrl.sv
// controller state machine sequencing each operation
module wsrq_ctrl import wsrq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_RD     = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_MRD    = 7'b0010000,
    S_MWR    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_stall  = state != S_IDLE;
  assign out_valid = state == S_DONE;

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.status_code = ST_OK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.bad) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_BADCPU;
          state_next      = S_DONE;
        end else begin
          case (stat.op)
            OP_ENQUEUE: begin
              if (stat.full) begin
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_FULL;
              end else begin
                cmd.push_tid = 1'b1;
              end
              state_next = S_DONE;
            end
            OP_DEQUEUE, OP_PEEK: begin
              if (stat.empty) begin
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_EMPTY;
                state_next      = S_DONE;
              end else begin
                state_next = S_RD;
              end
            end
            default: begin
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN;
            end
          endcase
        end
      end
      S_RD: begin
        cmd.take_head = 1'b1;
        cmd.pop_c     = stat.op == OP_DEQUEUE;
        state_next    = S_DONE;
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          if (!stat.pass) begin
            cmd.scan_pass = 1'b1;
          end else begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_EMPTY;
            state_next      = S_DONE;
          end
        end else if (stat.eligible) begin
          cmd.grab   = 1'b1;
          state_next = S_MRD;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_MRD: begin
        cmd.rd_vic = 1'b1;
        cmd.pop_v  = 1'b1;
        state_next = S_MWR;
      end
      S_MWR: begin
        cmd.move   = 1'b1;
        state_next = stat.last ? S_DONE : S_MRD;
      end
      S_DONE: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == S_DECODE)
    else $error("accepted item did not reach decode");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> state == S_IDLE)
    else $error("result transfer did not return to idle");

  a_move_loop: assert property (@(posedge clk) disable iff (rst)
    (state == S_MWR && !stat.last) |=> state == S_MRD)
    else $error("steal move ended early");

  a_rd_done: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |=> state == S_DONE)
    else $error("head read did not finish");

endmodule
